FILE: rtl/pfr_pkg.sv
// Package: protocol codes, header bytes, frame lengths and shared structs of the frame receiver.
`default_nettype none
package pfr_pkg;

  localparam int ByteW  = 8;
  localparam int IndexW = 3;
  localparam int ProtoW = 2;

  // Number of byte cells in the chain: the longest frame.
  localparam int ChainLen = 8;

  localparam logic [ProtoW-1:0] PROTO_D  = 2'd0;
  localparam logic [ProtoW-1:0] PROTO_P  = 2'd1;
  localparam logic [ProtoW-1:0] PROTO_CL = 2'd2;

  localparam logic [ByteW-1:0] HDR_PELCO_D = 8'hff;
  localparam logic [ByteW-1:0] HDR_PELCO_P = 8'ha0;

  // Index of the final byte for each frame length.
  localparam logic [IndexW-1:0] LAST_IDX_D     = 3'd6;
  localparam logic [IndexW-1:0] LAST_IDX_OTHER = 3'd7;

  localparam logic [3:0] ADDR_NIBBLE_MARK = 4'h8;

  // Configuration register indexes.
  localparam logic [1:0] REG_AUTO_DETECT   = 2'd0;
  localparam logic [1:0] REG_FIXED_PROTO   = 2'd1;
  localparam logic [1:0] REG_CL_HEADER     = 2'd2;

  typedef struct packed {
    logic              auto_detect;
    logic [ProtoW-1:0] fixed_protocol;
    logic [ByteW-1:0]  camera_link_header;
  } pfr_cfg_t;

  // Control from the sequencer to the byte chain.
  typedef struct packed {
    logic             shift;
    logic [ByteW-1:0] data;
    logic             tap_short;
  } pfr_chain_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/pfr_byte_if.sv
// Interface: received byte channel.
`default_nettype none
interface pfr_byte_if;
  import pfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfr_frame_if.sv
// Interface: frame byte result channel.
`default_nettype none
interface pfr_frame_if;
  import pfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  frame_byte;
  logic [IndexW-1:0] byte_index;
  logic              last_byte;
  logic [ProtoW-1:0] frame_protocol;
  logic [ByteW-1:0]  frame_address;

  modport source (output valid, output frame_byte, output byte_index, output last_byte,
                  output frame_protocol, output frame_address, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                  input frame_protocol, input frame_address, output ready);
endinterface
`default_nettype wire

FILE: rtl/pfr_cell.sv
// Byte cell: one stage of the frame shift chain.
`default_nettype none
module pfr_cell
  import pfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [ByteW-1:0] d,
  output logic      [ByteW-1:0] q
);

  logic [ByteW-1:0] held;

  // Take the neighbour's byte when the chain advances, otherwise hold.
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule
`default_nettype wire

FILE: rtl/pfr_ctrl.sv
// Sequencer: header detection, byte counting, address extraction and frame emission.
`default_nettype none
module pfr_ctrl
  import pfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfr_cfg_t          cfg,
  input  wire logic              rx_valid,
  input  wire logic [ByteW-1:0]  rx_byte,
  output logic                   rx_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IndexW-1:0]      out_index,
  output logic                   out_last,
  output logic [ProtoW-1:0]      out_protocol,
  output logic [ByteW-1:0]       out_address,
  output pfr_chain_ctl_t         chain_ctl
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [IndexW-1:0] count;
  logic [IndexW-1:0] index;
  logic [ProtoW-1:0] proto;
  logic [ByteW-1:0]  byte0;
  logic [ByteW-1:0]  byte1;
  logic [ByteW-1:0]  address;

  logic              accept;
  logic              hdr_ok;
  logic [ProtoW-1:0] hdr_proto;
  logic [ProtoW-1:0] fixed_norm;
  logic [IndexW-1:0] last_idx;
  logic [ByteW-1:0]  addr_low;
  logic [ByteW-1:0]  address_next;

  assign accept   = rx_valid && (state != ST_EMIT);
  assign last_idx = (proto == PROTO_D) ? LAST_IDX_D : LAST_IDX_OTHER;

  // Unused code 3 of the fixed protocol behaves as camera link.
  assign fixed_norm = (cfg.fixed_protocol > PROTO_CL) ? PROTO_CL : cfg.fixed_protocol;

  always_comb begin
    hdr_ok    = 1'b0;
    hdr_proto = fixed_norm;
    if (cfg.auto_detect) begin
      // Pelco headers win over a colliding camera-link header.
      if (rx_byte == HDR_PELCO_D) begin
        hdr_ok    = 1'b1;
        hdr_proto = PROTO_D;
      end else if (rx_byte == HDR_PELCO_P) begin
        hdr_ok    = 1'b1;
        hdr_proto = PROTO_P;
      end else if (rx_byte == cfg.camera_link_header) begin
        hdr_ok    = 1'b1;
        hdr_proto = PROTO_CL;
      end
    end else begin
      case (fixed_norm)
        PROTO_D: hdr_ok = (rx_byte == HDR_PELCO_D);
        PROTO_P: hdr_ok = (rx_byte == HDR_PELCO_P);
        default: hdr_ok = 1'b1;
      endcase
    end
  end

  always_comb begin
    addr_low = byte1;
    if ((byte0 == HDR_PELCO_P) && (proto == PROTO_P)) begin
      addr_low = byte1 + 8'd1;
    end
    if (byte0[7:4] == ADDR_NIBBLE_MARK) begin
      address_next = {byte0[3:0], addr_low[3:0]};
    end else begin
      address_next = addr_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      count <= '0;
      index <= '0;
      proto <= PROTO_D;
    end else begin
      case (state)
        ST_HUNT: begin
          if (accept && hdr_ok) begin
            proto <= hdr_proto;
            byte0 <= rx_byte;
            count <= 3'd1;
            state <= ST_COLLECT;
          end
        end
        ST_COLLECT: begin
          if (accept) begin
            if (count == 3'd1) begin
              byte1 <= rx_byte;
            end
            count <= count + 3'd1;
            if (count == last_idx) begin
              address <= address_next;
              index   <= '0;
              state   <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            index <= index + 3'd1;
            if (index == last_idx) begin
              count <= '0;
              state <= ST_HUNT;
            end
          end
        end
        default: begin
          state <= ST_HUNT;
        end
      endcase
    end
  end

  assign rx_ready     = (state != ST_EMIT);
  assign out_valid    = (state == ST_EMIT);
  assign out_index    = index;
  assign out_last     = (index == last_idx);
  assign out_protocol = proto;
  assign out_address  = address;

  assign chain_ctl.shift = (accept && ((state == ST_COLLECT) || hdr_ok))
                        || ((state == ST_EMIT) && out_ready);
  assign chain_ctl.data      = rx_byte;
  assign chain_ctl.tap_short = (proto == PROTO_D);

endmodule
`default_nettype wire

FILE: rtl/pelco_frame_receiver_top.sv
// Top level: Pelco-D / Pelco-P / camera-link frame receiver with a byte-cell shift chain.
// Output: the first result of a frame is valid the cycle after its final byte is accepted.
// Throughput: one byte per cycle while collecting; a completed frame then drains 7 or 8
//   results, one per cycle with frames.ready high, and rx.ready stays low until the last.
// Reset: rst (synchronous) returns to header hunting and loads auto_detect=1,
//   fixed_protocol=0, camera_link_header=0; the byte cells are not reset.
`default_nettype none
module pelco_frame_receiver_top
  import pfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  pfr_byte_if.sink        rx,
  pfr_frame_if.source     frames,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  pfr_cfg_t       cfg;
  pfr_chain_ctl_t chain_ctl;

  logic [ByteW-1:0] cell_q [ChainLen];

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_detect        <= 1'b1;
      cfg.fixed_protocol     <= PROTO_D;
      cfg.camera_link_header <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_DETECT: cfg.auto_detect        <= cfg_data[0];
        REG_FIXED_PROTO: cfg.fixed_protocol     <= cfg_data[ProtoW-1:0];
        REG_CL_HEADER:   cfg.camera_link_header <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: decides when the chain advances and tags each outgoing byte.
  pfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rx_valid     (rx.valid),
    .rx_byte      (rx.byte_in),
    .rx_ready     (rx.ready),
    .out_valid    (frames.valid),
    .out_ready    (frames.ready),
    .out_index    (frames.byte_index),
    .out_last     (frames.last_byte),
    .out_protocol (frames.frame_protocol),
    .out_address  (frames.frame_address),
    .chain_ctl    (chain_ctl)
  );

  // Byte chain: accepted header and body bytes enter at cell 0 and advance one cell each.
  // Once a frame is complete its first byte sits in the tap cell, and each delivered
  // result advances the chain so the next byte moves into the tap.
  for (genvar i = 0; i < ChainLen; i++) begin : g_cell
    logic [ByteW-1:0] d;
    if (i == 0) begin : g_head
      assign d = chain_ctl.data;
    end else begin : g_body
      assign d = cell_q[i-1];
    end
    pfr_cell u_cell (
      .clk   (clk),
      .shift (chain_ctl.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  // Tap: a 7-byte Pelco-D frame ends one cell short of the far end.
  assign frames.frame_byte = chain_ctl.tap_short ? cell_q[ChainLen-2] : cell_q[ChainLen-1];

endmodule
`default_nettype wire

FILE: tb/sv/tb_pelco_frame_receiver_top.sv
// Testbench: random and directed frame traffic for the Pelco frame receiver, self-checking.
`timescale 1ns / 1ps
module tb_pelco_frame_receiver_top;
  import pfr_pkg::*;

  // Requests to take in the random part; the directed part comes on top.
  localparam int RandomRequests = 180;
  // Settings that are always visited, extremes and corner cases among them.
  localparam int FixedSettings  = 8;
  // Cycles to let pass once nothing is expected, to cover any byte still in flight.
  localparam int SettleCycles   = 4;
  // Cycles with no request moving on either side before the run is abandoned.
  localparam int WatchdogLimit  = 2000;

  typedef struct packed {
    logic [ByteW-1:0]  frame_byte;
    logic [IndexW-1:0] byte_index;
    logic              last_byte;
    logic [ProtoW-1:0] frame_protocol;
    logic [ByteW-1:0]  frame_address;
  } frame_res_t;

  // Frame assembler model plus the queue of frame bytes it has promised.
  class frame_scoreboard;
    logic              auto_detect;
    logic [ProtoW-1:0] fixed_protocol;
    logic [ByteW-1:0]  cl_header;
    bit                in_frame;
    int unsigned       got;
    logic [ProtoW-1:0] proto;
    logic [ByteW-1:0]  held [ChainLen];
    frame_res_t        pending [$];
    int unsigned       mismatches;
    int unsigned       frames_done;
    int unsigned       results_seen;

    function new();
      auto_detect    = 1'b1;
      fixed_protocol = PROTO_D;
      cl_header      = 8'h00;
      in_frame       = 1'b0;
      got            = 0;
      proto          = PROTO_D;
      foreach (held[i]) held[i] = 8'h00;
      mismatches     = 0;
      frames_done    = 0;
      results_seen   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_AUTO_DETECT: auto_detect    = val[0];
        REG_FIXED_PROTO: fixed_protocol = val[1:0];
        REG_CL_HEADER:   cl_header      = val;
        default: ;
      endcase
    endfunction

    // Take one received byte; return 1 if it was used (header or body).
    function bit note_request(logic [ByteW-1:0] b);
      logic [ProtoW-1:0] p;
      int unsigned       flen;
      logic [ByteW-1:0]  a0;
      logic [ByteW-1:0]  a1;
      logic [ByteW-1:0]  addr;
      frame_res_t        r;
      if (!in_frame) begin
        if (auto_detect) begin
          // Pelco headers win over a colliding camera-link header.
          if (b == HDR_PELCO_D) p = PROTO_D;
          else if (b == HDR_PELCO_P) p = PROTO_P;
          else if (b == cl_header) p = PROTO_CL;
          else return 1'b0;
        end else begin
          // The unused code 3 behaves as camera link.
          p = (fixed_protocol > PROTO_CL) ? PROTO_CL : fixed_protocol;
          if (p == PROTO_D && b != HDR_PELCO_D) return 1'b0;
          if (p == PROTO_P && b != HDR_PELCO_P) return 1'b0;
        end
        proto    = p;
        held[0]  = b;
        got      = 1;
        in_frame = 1'b1;
        return 1'b1;
      end
      flen = (proto == PROTO_D) ? 7 : 8;
      held[got] = b;
      got++;
      if (got < flen) return 1'b1;
      a0 = held[0];
      a1 = held[1];
      if (a0 == HDR_PELCO_P && proto == PROTO_P) a1 = a1 + 8'd1;
      addr = (a0[7:4] == ADDR_NIBBLE_MARK) ? {a0[3:0], a1[3:0]} : a1;
      for (int k = 0; k < flen; k++) begin
        r.frame_byte     = held[k];
        r.byte_index     = k[IndexW-1:0];
        r.last_byte      = (k == flen - 1);
        r.frame_protocol = proto;
        r.frame_address  = addr;
        pending.push_back(r);
      end
      in_frame = 1'b0;
      got      = 0;
      frames_done++;
      return 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [ByteW-1:0] fb, logic [IndexW-1:0] idx, logic lst,
                      logic [ProtoW-1:0] pr, logic [ByteW-1:0] ad);
      frame_res_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected frame byte %02h at index %0d", fb, idx));
        return;
      end
      want = pending.pop_front();
      if (fb !== want.frame_byte)
        report($sformatf("frame_byte %02h, expected %02h", fb, want.frame_byte));
      if (idx !== want.byte_index)
        report($sformatf("byte_index %0d, expected %0d", idx, want.byte_index));
      if (lst !== want.last_byte)
        report($sformatf("last_byte %b, expected %b at index %0d", lst, want.last_byte,
                         want.byte_index));
      if (pr !== want.frame_protocol)
        report($sformatf("frame_protocol %0d, expected %0d", pr, want.frame_protocol));
      if (ad !== want.frame_address)
        report($sformatf("frame_address %02h, expected %02h", ad, want.frame_address));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  pfr_byte_if  rx_bus ();
  pfr_frame_if frame_bus ();

  pelco_frame_receiver_top dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_bus),
    .frames    (frame_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_scoreboard sb = new();

  int taken;         // requests the receiver actually used
  int phase;         // register setting in force
  bit zero_gap;      // hold the byte stream back-to-back for this setting
  bit zero_stall;    // keep frame ready high for this setting
  int stall_left;
  int pause;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Frame sink: stall at random after each accepted frame byte unless zero_stall is set,
  // and check every accepted byte against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      frame_bus.ready <= 1'b0;
      stall_left      <= 0;
    end else if (frame_bus.valid && frame_bus.ready) begin
      sb.check_result(frame_bus.frame_byte, frame_bus.byte_index, frame_bus.last_byte,
                      frame_bus.frame_protocol, frame_bus.frame_address);
      pause = zero_stall ? 0 : $urandom_range(4, 0);
      frame_bus.ready <= (pause == 0);
      stall_left      <= pause;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      frame_bus.ready <= (stall_left == 1);
    end else begin
      frame_bus.ready <= 1'b1;
    end
  end

  // Watchdog: abandon the run if no request moves on either side for too long,
  // which also catches predicted frame bytes that never turn up.
  always @(posedge clk) begin
    if (rst || (rx_bus.valid && rx_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d frame bytes outstanding",
               idle_cycles, sb.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Extremes are drawn often so header and address corners keep turning up.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // Offer one byte after a random gap; hold it until the receiver takes it.
  task automatic send_request(input logic [7:0] b);
    int gap;
    gap = zero_gap ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.byte_in <= b;
    do @(posedge clk); while (!(rx_bus.valid && rx_bus.ready));
    if (sb.note_request(b)) taken++;
  endtask

  // Drop valid, wait for every predicted byte, then let the pipeline settle.
  task automatic drain();
    rx_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles, keeping the model in step.
  task automatic load_config(input logic [7:0] ad_val, input logic [7:0] fp_val,
                             input logic [7:0] hdr_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AUTO_DETECT;
    cfg_data  <= ad_val;
    @(posedge clk);
    cfg_index <= REG_FIXED_PROTO;
    cfg_data  <= fp_val;
    @(posedge clk);
    cfg_index <= REG_CL_HEADER;
    cfg_data  <= hdr_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_AUTO_DETECT, ad_val);
    sb.write_reg(REG_FIXED_PROTO, fp_val);
    sb.write_reg(REG_CL_HEADER, hdr_val);
  endtask

  initial begin
    bit               ad;
    logic [1:0]       fp;
    logic [7:0]       ch;
    logic [7:0]       ca;
    logic [7:0]       cf;
    logic [7:0]       hdr;
    int               nbody;
    int               start_taken;

    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_AUTO_DETECT;
    cfg_data       <= 8'h00;
    rx_bus.valid   <= 1'b0;
    rx_bus.byte_in <= 8'h00;
    taken      = 0;
    phase      = 0;
    zero_gap   = 1'b0;
    zero_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: auto-detect on, camera-link header 0x00.
    // Drop a stray byte, then one frame of each protocol with extreme bytes.
    send_request(8'h55);
    send_request(HDR_PELCO_D);
    send_request(8'h01);
    send_request(8'h00);
    send_request(8'hff);
    send_request(8'h80);
    send_request(8'h7f);
    send_request(8'h00);
    // Pelco-P with address byte 0xff: the address wraps round to zero.
    send_request(HDR_PELCO_P);
    send_request(8'hff);
    send_request(8'h55);
    send_request(8'haa);
    send_request(8'h00);
    send_request(8'hff);
    send_request(8'h01);
    send_request(8'hfe);
    // Camera-link frame on header 0x00.
    send_request(8'h00);
    send_request(8'h12);
    send_request(8'h34);
    send_request(8'h56);
    send_request(8'h78);
    send_request(8'h9a);
    send_request(8'hbc);
    send_request(8'hde);
    drain();
    // Register write mid-frame: the Pelco-D framing latched at the header must hold.
    send_request(HDR_PELCO_D);
    drain();
    load_config(8'h00, {6'd0, PROTO_P}, 8'h85);
    send_request(8'h10);
    send_request(8'h20);
    send_request(8'h30);
    send_request(8'h40);
    send_request(8'h50);
    send_request(8'h60);

    // Random part: mostly well-formed frames with random content, some stray
    // bytes and truncated frames, under a fresh register setting each phase.
    start_taken = taken;
    while (taken - start_taken < RandomRequests || phase < FixedSettings) begin
      case (phase)
        0: begin ad = 1'b1; fp = PROTO_D;  ch = HDR_PELCO_D; end  // collides with Pelco-D
        1: begin ad = 1'b1; fp = PROTO_CL; ch = HDR_PELCO_P; end  // collides with Pelco-P
        2: begin ad = 1'b1; fp = PROTO_P;  ch = 8'h8c;       end  // nibble-merged address
        3: begin ad = 1'b0; fp = PROTO_D;  ch = 8'h00;       end
        4: begin ad = 1'b0; fp = PROTO_P;  ch = 8'hff;       end
        5: begin ad = 1'b0; fp = PROTO_CL; ch = 8'h00;       end
        6: begin ad = 1'b0; fp = 2'd3;     ch = 8'h80;       end  // unused protocol code
        7: begin ad = 1'b1; fp = 2'd3;     ch = 8'hff;       end
        default: begin
          ad = 1'($urandom_range(1, 0));
          fp = 2'($urandom_range(3, 0));
          ch = rand_byte();
          if ($urandom_range(3, 0) == 0) ch[7:4] = ADDR_NIBBLE_MARK;
        end
      endcase
      // Fill the unused register bits with noise; only the low bits count.
      ca = 8'($urandom_range(255, 0));
      ca[0] = ad;
      cf = 8'($urandom_range(255, 0));
      cf[1:0] = fp;
      drain();
      load_config(ca, cf, ch);
      zero_gap   = ($urandom_range(3, 0) == 0);
      zero_stall = ($urandom_range(3, 0) == 0);

      repeat ($urandom_range(4, 2)) begin
        if ($urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(4, 1)) send_request(rand_byte());
        end else begin
          // Finish off any frame a stray byte opened, so the next header lands.
          while (sb.in_frame) send_request(rand_byte());
          if (ad) begin
            case ($urandom_range(2, 0))
              0: hdr = HDR_PELCO_D;
              1: hdr = HDR_PELCO_P;
              default: hdr = ch;
            endcase
          end else if (fp == PROTO_D) begin
            hdr = HDR_PELCO_D;
          end else if (fp == PROTO_P) begin
            hdr = HDR_PELCO_P;
          end else begin
            hdr = rand_byte();
            if ($urandom_range(3, 0) == 0) hdr[7:4] = ADDR_NIBBLE_MARK;
          end
          send_request(hdr);
          nbody = !sb.in_frame ? 0 : (sb.proto == PROTO_D) ? 6 : 7;
          // Now and then cut the frame short so the next header is swallowed.
          if (nbody > 0 && $urandom_range(7, 0) == 0) nbody -= $urandom_range(3, 1);
          repeat (nbody) send_request(rand_byte());
        end
      end
      phase++;
    end

    drain();
    $display("covered %0d requests over %0d register settings: %0d frames, %0d bytes checked",
             taken, phase + 2, sb.frames_done, sb.results_seen);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfr_pkg.sv
rtl/pfr_byte_if.sv
rtl/pfr_frame_if.sv
rtl/pfr_cell.sv
rtl/pfr_ctrl.sv
rtl/pelco_frame_receiver_top.sv
tb/sv/tb_pelco_frame_receiver_top.sv
